@@ design/mcfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers of the motor command frame scheduler.
// No dependencies; used by every module of the block.
package mcfs_pkg;

	// Frame kinds as they appear on frame_kind
	typedef enum logic [2:0] {
		KIND_CURRENT,
		KIND_SPEED,
		KIND_DUTY,
		KIND_TYPE,
		KIND_DIR
	} frame_kind_t;

	// Control mode codes; any other code runs as current mode
	localparam logic [1:0] MODE_SPEED = 2'd1;
	localparam logic [1:0] MODE_DUTY  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_CURRENT_LIMIT = 3'd0;
	localparam logic [2:0] REG_SPEED_LIMIT   = 3'd1;
	localparam logic [2:0] REG_DUTY_LIMIT    = 3'd2;
	localparam logic [2:0] REG_KEEPALIVE     = 3'd3;
	localparam logic [2:0] REG_STALE_LIMIT   = 3'd4;

	// Reset values
	localparam logic [14:0] CURRENT_LIMIT_RST = 15'd32767;
	localparam logic [30:0] SPEED_LIMIT_RST   = 31'h7FFF_FFFF;
	localparam logic [13:0] DUTY_LIMIT_RST    = 14'd10000;
	localparam logic [15:0] KEEPALIVE_RST     = 16'd200;
	localparam logic [15:0] STALE_LIMIT_RST   = 16'd40;
	localparam logic [16:0] AGE_RST           = 17'd200;
	localparam logic [7:0]  PREV_TYPE_RST     = 8'hFF;

	localparam logic [16:0] AGE_MAX        = 17'h1FFFF;
	localparam logic [15:0] STATUS_AGE_MAX = 16'hFFFF;

	// Default depth of the period queue between front and back
	localparam int Q_DEPTH_DEF = 4;

	// Back end sequencer: which frame of the head period goes out next
	typedef enum logic [1:0] {
		PH_DEMAND,
		PH_TYPE,
		PH_DIR
	} phase_t;

	// One accepted control period
	typedef struct packed {
		logic [1:0]         ctrl_mode;
		logic signed [15:0] current_cmd;
		logic signed [31:0] speed_cmd;
		logic signed [15:0] duty_cmd;
		logic [7:0]         flight_mode;
		logic [7:0]         motor_code;
		logic               dir_invert;
		logic               status_received;
	} item_t;

	// Classified period: everything the back end needs to emit its frames
	typedef struct packed {
		frame_kind_t        dem_kind;
		logic signed [31:0] dem_value;
		logic [7:0]         mode;
		logic [7:0]         dem_seq;
		logic               fault;
		logic               send_type;
		logic [7:0]         type_val;
		logic [7:0]         type_seq;
		logic               send_dir;
		logic               dir_val;
		logic [7:0]         dir_seq;
	} period_rec_t;

	// Symmetric clamp of a signed value to [-lim, lim]
	function automatic logic signed [31:0] clamp_sym(input logic signed [32:0] v,
			input logic [30:0] lim);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = signed'({2'b00, lim});
		lo = -hi;
		if (v < lo) begin
			return lo[31:0];
		end else if (v > hi) begin
			return hi[31:0];
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

@@ design/mcfs_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration registers, per-period state update and frame selection.
// Depends on mcfs_pkg; writes one period record per accepted item.
module mcfs_front import mcfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        accept,
	input  item_t       item,
	output period_rec_t rec
);

	logic [14:0] current_limit_q;
	logic [30:0] speed_limit_q;
	logic [13:0] duty_limit_q;
	logic [15:0] keepalive_q;
	logic [15:0] stale_limit_q;

	logic [7:0]  demand_seq_q;
	logic [7:0]  type_seq_q;
	logic [7:0]  dir_seq_q;
	logic [7:0]  prev_type_q;
	logic        prev_dir_known_q;
	logic        prev_dir_q;
	logic [16:0] type_age_q;
	logic [16:0] dir_age_q;
	logic [15:0] status_age_q;
	logic        seen_q;
	logic        fault_q;

	logic [15:0]        status_age_d;
	logic               seen_d;
	logic               fault_d;
	logic [16:0]        type_age_inc;
	logic [16:0]        dir_age_inc;
	logic               send_type;
	logic               send_dir;
	logic signed [32:0] dem_in;
	logic [30:0]        dem_lim;
	frame_kind_t        dem_kind;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_limit_q <= CURRENT_LIMIT_RST;
			speed_limit_q   <= SPEED_LIMIT_RST;
			duty_limit_q    <= DUTY_LIMIT_RST;
			keepalive_q     <= KEEPALIVE_RST;
			stale_limit_q   <= STALE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CURRENT_LIMIT: current_limit_q <= cfg_data[14:0];
				REG_SPEED_LIMIT:   speed_limit_q   <= cfg_data[30:0];
				REG_DUTY_LIMIT:    duty_limit_q    <= cfg_data[13:0];
				REG_KEEPALIVE:     keepalive_q     <= cfg_data[15:0];
				REG_STALE_LIMIT:   stale_limit_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// staleness: receipt clears, fault latches once age passes the limit
	always_comb begin
		status_age_d = status_age_q;
		seen_d       = seen_q;
		fault_d      = fault_q;
		if (item.status_received) begin
			status_age_d = '0;
			seen_d       = 1'b1;
			fault_d      = 1'b0;
		end else if (seen_q && status_age_q != STATUS_AGE_MAX) begin
			status_age_d = status_age_q + 16'd1;
		end
		if (seen_d && status_age_d > stale_limit_q) begin
			fault_d = 1'b1;
		end
	end

	// keep-alive ages saturate, then a send resets them
	assign type_age_inc = (type_age_q != AGE_MAX) ? type_age_q + 17'd1 : type_age_q;
	assign dir_age_inc  = (dir_age_q != AGE_MAX) ? dir_age_q + 17'd1 : dir_age_q;
	assign send_type = (item.motor_code != prev_type_q) ||
		(type_age_inc >= {1'b0, keepalive_q});
	assign send_dir  = !prev_dir_known_q || (item.dir_invert != prev_dir_q) ||
		(dir_age_inc >= {1'b0, keepalive_q});

	// demand select, then one shared clamp
	always_comb begin
		case (item.ctrl_mode)
			MODE_SPEED: begin
				dem_kind = KIND_SPEED;
				dem_in   = {item.speed_cmd[31], item.speed_cmd};
				dem_lim  = speed_limit_q;
			end
			MODE_DUTY: begin
				dem_kind = KIND_DUTY;
				dem_in   = {{17{item.duty_cmd[15]}}, item.duty_cmd};
				dem_lim  = {17'd0, duty_limit_q};
			end
			default: begin
				dem_kind = KIND_CURRENT;
				dem_in   = {{17{item.current_cmd[15]}}, item.current_cmd};
				dem_lim  = {16'd0, current_limit_q};
			end
		endcase
	end

	always_comb begin
		rec.dem_kind  = dem_kind;
		rec.dem_value = clamp_sym(dem_in, dem_lim);
		rec.mode      = item.flight_mode;
		rec.dem_seq   = demand_seq_q;
		rec.fault     = fault_d;
		rec.send_type = send_type;
		rec.type_val  = item.motor_code;
		rec.type_seq  = type_seq_q;
		rec.send_dir  = send_dir;
		rec.dir_val   = item.dir_invert;
		rec.dir_seq   = dir_seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			demand_seq_q     <= '0;
			type_seq_q       <= '0;
			dir_seq_q        <= '0;
			prev_type_q      <= PREV_TYPE_RST;
			prev_dir_known_q <= 1'b0;
			prev_dir_q       <= 1'b0;
			type_age_q       <= AGE_RST;
			dir_age_q        <= AGE_RST;
			status_age_q     <= '0;
			seen_q           <= 1'b0;
			fault_q          <= 1'b0;
		end else if (accept) begin
			demand_seq_q <= demand_seq_q + 8'd1;
			status_age_q <= status_age_d;
			seen_q       <= seen_d;
			fault_q      <= fault_d;
			if (send_type) begin
				type_seq_q  <= type_seq_q + 8'd1;
				prev_type_q <= item.motor_code;
				type_age_q  <= '0;
			end else begin
				type_age_q <= type_age_inc;
			end
			if (send_dir) begin
				dir_seq_q        <= dir_seq_q + 8'd1;
				prev_dir_known_q <= 1'b1;
				prev_dir_q       <= item.dir_invert;
				dir_age_q        <= '0;
			end else begin
				dir_age_q <= dir_age_inc;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_fault_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |-> seen_q)
		else $error("stale fault set before any status receipt");
	a_type_age_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && send_type |=> type_age_q == '0 && prev_type_q == $past(item.motor_code))
		else $error("type frame sent without clearing its age");
`endif

endmodule

@@ design/mcfs_queue.sv @@
`timescale 1ns / 1ps
// Short queue of period records between front and back ends.
// Depends on mcfs_pkg for the record type.
module mcfs_queue import mcfs_pkg::*; #(
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  period_rec_t wr_rec,
	output logic        full,
	input  logic        rd_en,
	output period_rec_t rd_rec,
	output logic        empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	period_rec_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH) && !(rd_en && empty) && !(wr_en && full))
		else $error("period queue over- or underflow");
`endif

endmodule

@@ design/mcfs_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the head period record frame by frame into the output register.
// Depends on mcfs_pkg for the record, phase and frame kind types.
module mcfs_back import mcfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  period_rec_t        rec,
	input  logic               rec_valid,
	output logic               rec_pop,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         frame_kind,
	output logic signed [31:0] payload,
	output logic [7:0]         frame_mode,
	output logic [7:0]         sequence_res,
	output logic               stale_fault,
	output logic               last_of_period
);

	phase_t             phase_q;
	phase_t             phase_d;
	phase_t             phase_nxt;
	logic               out_valid_q;
	logic               load;
	frame_kind_t        kind_sel;
	logic signed [31:0] payload_sel;
	logic [7:0]         seq_sel;
	logic               last_sel;

	frame_kind_t        kind_q;
	logic signed [31:0] payload_q;
	logic [7:0]         mode_q;
	logic [7:0]         seq_q;
	logic               fault_q;
	logic               last_q;

	assign load    = rec_valid && (!out_valid_q || pop);
	assign rec_pop = load && last_sel;
	assign empty   = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DEMAND;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			out_valid_q <= load || (out_valid_q && !pop);
		end
	end

	always_comb begin
		kind_sel    = rec.dem_kind;
		payload_sel = rec.dem_value;
		seq_sel     = rec.dem_seq;
		last_sel    = 1'b0;
		phase_nxt   = PH_DEMAND;
		case (phase_q)
			PH_DEMAND: begin
				last_sel = !rec.send_type && !rec.send_dir;
				if (rec.send_type) begin
					phase_nxt = PH_TYPE;
				end else if (rec.send_dir) begin
					phase_nxt = PH_DIR;
				end
			end
			PH_TYPE: begin
				kind_sel    = KIND_TYPE;
				payload_sel = {24'd0, rec.type_val};
				seq_sel     = rec.type_seq;
				last_sel    = !rec.send_dir;
				if (rec.send_dir) begin
					phase_nxt = PH_DIR;
				end
			end
			PH_DIR: begin
				kind_sel    = KIND_DIR;
				payload_sel = {31'd0, rec.dir_val};
				seq_sel     = rec.dir_seq;
				last_sel    = 1'b1;
			end
			default: ;
		endcase
		phase_d = load ? phase_nxt : phase_q;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= kind_sel;
			payload_q <= payload_sel;
			mode_q    <= rec.mode;
			seq_q     <= seq_sel;
			fault_q   <= rec.fault;
			last_q    <= last_sel;
		end
	end

	assign frame_kind     = kind_q;
	assign payload        = payload_q;
	assign frame_mode     = mode_q;
	assign sequence_res   = seq_q;
	assign stale_fault    = fault_q;
	assign last_of_period = last_q;

`ifndef NO_ASSERTIONS
	a_new_period_at_demand: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |=> phase_q == PH_DEMAND)
		else $error("sequencer did not return to the demand frame");
	a_head_held_midway: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DEMAND |-> rec_valid)
		else $error("period record left the queue before its last frame");
`endif

endmodule

@@ design/motor_command_frame_scheduler.sv @@
`timescale 1ns / 1ps
// Motor command frame scheduler: one input item per control period, one to three
// frames out (demand, then motor type and direction when changed or kept alive).
// Depends on mcfs_pkg, mcfs_front, mcfs_queue and mcfs_back.
//
// Each accepted item is one control period. The front end updates the
// stale-status state, clamps the demand selected by ctrl_mode and decides
// whether motor-type and invert-direction frames go out, all in the accept
// cycle, and writes one period record into a QUEUE_DEPTH-entry queue
// (default 4). The back end walks the head record and places one frame per
// cycle in an output register while pop keeps it free. Frames come out in
// the order demand, motor type, direction; last_of_period marks the final
// frame of each period and stale_fault carries the fault after that
// period's update. Rate: an item is accepted in any cycle the queue has
// room (full low); its record is registered in the queue, and the back end
// then loads its first frame into the output register once that is free.
// The output port moves one frame per cycle while pop is high, and the
// sustained rate is set by how many frames each period emits. Config
// writes are taken every cycle (cfg_ready is always high); indexes beyond
// the five registers are ignored. Write config only while the block is idle.
module motor_command_frame_scheduler import mcfs_pkg::*; #(
	parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// period items in
	input  logic               push,
	output logic               full,
	input  logic [1:0]         ctrl_mode,
	input  logic signed [15:0] current_cmd,
	input  logic signed [31:0] speed_cmd,
	input  logic signed [15:0] duty_cmd,
	input  logic [7:0]         flight_mode,
	input  logic [7:0]         motor_code,
	input  logic               dir_invert,
	input  logic               status_received,
	// frames out
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         frame_kind,
	output logic signed [31:0] payload,
	output logic [7:0]         frame_mode,
	output logic [7:0]         sequence_res,
	output logic               stale_fault,
	output logic               last_of_period
);

	item_t       item;
	period_rec_t front_rec;
	period_rec_t head_rec;
	logic        accept;
	logic        q_empty;
	logic        rec_pop;

	assign accept = push && !full;

	always_comb begin
		item.ctrl_mode       = ctrl_mode;
		item.current_cmd     = current_cmd;
		item.speed_cmd       = speed_cmd;
		item.duty_cmd        = duty_cmd;
		item.flight_mode     = flight_mode;
		item.motor_code      = motor_code;
		item.dir_invert      = dir_invert;
		item.status_received = status_received;
	end

	mcfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.rec       (front_rec)
	);

	mcfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_rec (front_rec),
		.full   (full),
		.rd_en  (rec_pop),
		.rd_rec (head_rec),
		.empty  (q_empty)
	);

	mcfs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec            (head_rec),
		.rec_valid      (!q_empty),
		.rec_pop        (rec_pop),
		.empty          (empty),
		.pop            (pop),
		.frame_kind     (frame_kind),
		.payload        (payload),
		.frame_mode     (frame_mode),
		.sequence_res   (sequence_res),
		.stale_fault    (stale_fault),
		.last_of_period (last_of_period)
	);

endmodule
